// ===== hdl/esel_pkg.sv =====
`default_nettype none

package esel_pkg;

  // Field widths
  localparam int unsigned RpmW      = 12;
  localparam int unsigned TicksW    = 20;
  localparam int unsigned SinceStepW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;

  // Default debounce counter width
  localparam int unsigned DebounceCountWidth = 20;

  // Reset values
  localparam logic [RpmW-1:0]   RpmMinReset   = 12'd1;
  localparam logic [RpmW-1:0]   RpmMaxReset   = 12'd1500;
  localparam logic [TicksW-1:0] DebounceReset = 20'd20000;
  localparam logic [RpmW-1:0]   SetpointReset = 12'd100;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RPM_MIN   = 2'd0,
    CFG_RPM_MAX   = 2'd1,
    CFG_DEBOUNCE  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  // Quadrature step direction
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DN   = 2'd2,
    STEP_BAD  = 2'd3
  } step_e;

  // Indexed by {previous AB, current AB}
  localparam step_e QuadTable [16] = '{
    STEP_NONE, STEP_UP,   STEP_DN,   STEP_NONE,
    STEP_DN,   STEP_NONE, STEP_NONE, STEP_UP,
    STEP_UP,   STEP_NONE, STEP_NONE, STEP_DN,
    STEP_NONE, STEP_DN,   STEP_UP,   STEP_NONE
  };

  // Step interval thresholds in ticks
  localparam logic [SinceStepW-1:0] Thr25 = 16'd5000;
  localparam logic [SinceStepW-1:0] Thr10 = 16'd12000;
  localparam logic [SinceStepW-1:0] Thr5  = 16'd25000;
  localparam logic [SinceStepW-1:0] Thr2  = 16'd60000;

  // Setpoint change for a given interval between steps
  function automatic logic [4:0] step_size(input logic [SinceStepW-1:0] interval);
    logic [4:0] size;
    if (interval < Thr25) size = 5'd25;
    else if (interval < Thr10) size = 5'd10;
    else if (interval < Thr5) size = 5'd5;
    else if (interval < Thr2) size = 5'd2;
    else size = 5'd1;
    return size;
  endfunction

  // Button status handed from the debouncer
  typedef struct packed {
    logic phase_q;      // running before this sample
    logic running;      // running after this sample
    logic start_pulse;  // running begins with this sample
  } btn_status_t;

endpackage

`default_nettype wire

// ===== hdl/encoder_setpoint_selector.sv =====
// Encoder setpoint selector.
// Input stream: one request per microsecond sample, tdata carries enc_a (bit 0),
// enc_b (bit 1) and button_level (bit 2). Output stream: one result per
// request with rpm_setpoint (bits 11:0), running (bit 12), start_pulse (bit 13).
// Configuration: cfg_we_i writes register cfg_idx_i (0 rpm_min, 1 rpm_max,
// 2 debounce_ticks) at the clock edge; write only while the block is idle.
// Path: a request waits in the input register, then moves on to the result
// register once the result register is free or its result is being taken.
// Throughput: one request per cycle while the output side takes results; the state
// update for a sample is one pass of decode, add and clamp logic.
// Reset: both registers empty, setpoint 100, selecting phase, limits and
// debounce time at their defaults.
// Stall: while the result register holds a result that is not taken, the
// input register still fills once; s_axis_tready then drops until the
// output side moves again. Nothing is lost or repeated.
`default_nettype none

module encoder_setpoint_selector #(
  parameter int unsigned DEBOUNCE_COUNT_WIDTH = esel_pkg::DebounceCountWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [esel_pkg::InDataW-1:0]  s_axis_tdata,  // enc_a, enc_b, button_level
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [esel_pkg::OutDataW-1:0] m_axis_tdata,  // rpm_setpoint, running,
                                                            // start_pulse
  input  wire logic                          cfg_we_i,
  input  wire logic [esel_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [esel_pkg::CfgDataW-1:0] cfg_data_i
);
  import esel_pkg::*;

  logic [RpmW-1:0]   rpm_min_q, rpm_max_q;
  logic [TicksW-1:0] debounce_q;

  logic              in_valid_q;
  logic [2:0]        in_data_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic              advance;
  logic              update;
  logic [RpmW-1:0]   setpoint;
  btn_status_t       btn_status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_min_q  <= RpmMinReset;
      rpm_max_q  <= RpmMaxReset;
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RPM_MIN:  rpm_min_q  <= cfg_data_i[RpmW-1:0];
        CFG_RPM_MAX:  rpm_max_q  <= cfg_data_i[RpmW-1:0];
        CFG_DEBOUNCE: debounce_q <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline when the result register is free or being taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign update        = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[2:0];
    end
  end

  esel_setpoint u_setpoint (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .update_i   (update),
    .enc_a_i    (in_data_q[0]),
    .enc_b_i    (in_data_q[1]),
    .frozen_i   (btn_status.phase_q),
    .rpm_min_i  (rpm_min_q),
    .rpm_max_i  (rpm_max_q),
    .setpoint_o (setpoint)
  );

  esel_button #(
    .CountW (DEBOUNCE_COUNT_WIDTH)
  ) u_button (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .update_i         (update),
    .level_i          (in_data_q[2]),
    .debounce_ticks_i (debounce_q),
    .status_o         (btn_status)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update) begin
      out_data_q <= {2'b00, btn_status.start_pulse, btn_status.running, setpoint};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/esel_setpoint.sv =====
`default_nettype none

module esel_setpoint (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        update_i,
  input  wire logic                        enc_a_i,
  input  wire logic                        enc_b_i,
  input  wire logic                        frozen_i,
  input  wire logic [esel_pkg::RpmW-1:0]   rpm_min_i,
  input  wire logic [esel_pkg::RpmW-1:0]   rpm_max_i,
  output logic      [esel_pkg::RpmW-1:0]   setpoint_o
);
  import esel_pkg::*;

  logic [1:0]            prev_ab_q, prev_ab_d;
  logic [RpmW-1:0]       setpoint_q, setpoint_d;
  logic [SinceStepW-1:0] since_step_q, since_step_d;

  logic [1:0]            ab;
  step_e                 step;
  logic [SinceStepW-1:0] interval;
  logic [4:0]            size;
  logic signed [RpmW+1:0] sum;

  // Decode the step and adjust the setpoint
  always_comb begin
    ab        = {enc_a_i, enc_b_i};
    step      = QuadTable[{prev_ab_q, ab}];
    interval  = (since_step_q == '1) ? since_step_q : since_step_q + 1'b1;
    size      = step_size(interval);
    prev_ab_d = ab;
    since_step_d = interval;
    setpoint_d   = setpoint_q;
    sum          = '0;
    if (step == STEP_UP || step == STEP_DN) begin
      since_step_d = '0;
      if (!frozen_i) begin
        if (step == STEP_UP) begin
          sum = $signed({2'b00, setpoint_q}) + $signed({{(RpmW-3){1'b0}}, size});
        end else begin
          sum = $signed({2'b00, setpoint_q}) - $signed({{(RpmW-3){1'b0}}, size});
        end
        // Lower limit first, then upper limit
        if (sum < $signed({2'b00, rpm_min_i})) sum = $signed({2'b00, rpm_min_i});
        if (sum > $signed({2'b00, rpm_max_i})) sum = $signed({2'b00, rpm_max_i});
        setpoint_d = sum[RpmW-1:0];
      end
    end
  end

  // Hold state between samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ab_q    <= 2'b11;
      setpoint_q   <= SetpointReset;
      since_step_q <= '1;
    end else if (update_i) begin
      prev_ab_q    <= prev_ab_d;
      setpoint_q   <= setpoint_d;
      since_step_q <= since_step_d;
    end
  end

  assign setpoint_o = setpoint_d;

endmodule

`default_nettype wire

// ===== hdl/esel_button.sv =====
`default_nettype none

module esel_button #(
  parameter int unsigned CountW = esel_pkg::DebounceCountWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          update_i,
  input  wire logic                          level_i,
  input  wire logic [esel_pkg::TicksW-1:0]   debounce_ticks_i,
  output esel_pkg::btn_status_t              status_o
);
  import esel_pkg::*;

  localparam int unsigned CmpW = (CountW > TicksW) ? CountW : TicksW;

  logic              raw_q, raw_d;
  logic              stable_q, stable_d;
  logic [CountW-1:0] count_q, count_d;
  logic              phase_q, phase_d;
  logic              pulse;

  // Debounce the button and catch the press
  always_comb begin
    raw_d    = raw_q;
    stable_d = stable_q;
    count_d  = count_q;
    phase_d  = phase_q;
    pulse    = 1'b0;
    if (!phase_q) begin
      if (level_i != raw_q) begin
        raw_d   = level_i;
        count_d = '0;
      end else if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
      if (CmpW'(count_d) >= CmpW'(debounce_ticks_i) && level_i != stable_q) begin
        stable_d = level_i;
        if (stable_q && !level_i) begin
          phase_d = 1'b1;
          pulse   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b1;
      stable_q <= 1'b1;
      count_q  <= '1;
      phase_q  <= 1'b0;
    end else if (update_i) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      count_q  <= count_d;
      phase_q  <= phase_d;
    end
  end

  assign status_o = '{phase_q: phase_q, running: phase_d, start_pulse: pulse};

endmodule

`default_nettype wire
